>>> rtl/core/rbd_pkg.sv
// Package with types and constants shared by the ring buffer deque modules.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  typedef struct packed {
    logic go;
    logic done;
  } ctrl_t;

endpackage

>>> rtl/core/ring_buffer_deque_top.sv
// Top level of the ring buffer deque: controller plus datapath.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+-------------------------------
//   command  | start, busy           | command_i, value_i
//   result   | done_o (strobe)       | data_o, status_o, occupancy_o
//
// For each command the accepting edge updates pointers and count and issues
// the store access; the next cycle shows the result beat while the
// registered store read comes out. busy is high during the result cycle.
// A new command can be accepted in the cycle after done_o.
// Reset clears pointers, count and state; store contents stay undefined.
// The receiver cannot stall: done_o lasts one cycle.
`timescale 1ns / 1ps
module ring_buffer_deque_top
  import rbd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] data_o,
  output logic [1:0]               status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  ctrl_t ctrl;

  rbd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  rbd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .command_i   (command_i),
    .value_i     (value_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  assign done_o = ctrl.done;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o) else $error("missing result beat");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> occupancy_o <= OCC_W'(DEPTH)) else $error("occupancy above depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> occupancy_o == OCC_W'(DEPTH))
    else $error("full status while not full");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |-> occupancy_o == '0 && data_o == '1)
    else $error("bad empty pop result");
`endif

endmodule

>>> rtl/core/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rbd_ctrl.sv
// Controller state machine: accepts a command beat and presents its result.
`timescale 1ns / 1ps
module rbd_ctrl
  import rbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o       = 1'b0;
    ctrl_o.go    = 1'b0;
    ctrl_o.done  = 1'b0;
    case (state_q)
      S_IDLE: begin
        ctrl_o.go = start_i;
      end
      S_RESP: begin
        busy_o      = 1'b1;
        ctrl_o.done = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/core/rbd_dpath.sv
// Datapath: head and tail pointers, fill count, word store and result registers.
`timescale 1ns / 1ps
module rbd_dpath
  import rbd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  input  logic [1:0]               command_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic signed [WORD_W-1:0] data_o,
  output logic [1:0]               status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;
  logic             pop_ok_q, pop_ok_d;

  logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             we, re;
  logic [PTR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] rdata;
  cmd_e             cmd;

  assign cmd      = cmd_e'(command_i);
  assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
  assign head_dec = (head_q == '0) ? PTR_LAST : head_q - PTR_W'(1);
  assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
  assign tail_dec = (tail_q == '0) ? PTR_LAST : tail_q - PTR_W'(1);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = tail_q;
    raddr    = head_q;
    if (ctrl_i.go) begin
      status_d = ST_OK;
      pop_ok_d = 1'b0;
      case (cmd)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (count_q >= CNT_FULL) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
            if (cmd == CMD_PUSH_BACK) begin
              waddr  = tail_q;
              tail_d = tail_inc;
            end else begin
              waddr  = head_dec;
              head_d = head_dec;
            end
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            re       = 1'b1;
            pop_ok_d = 1'b1;
            count_d  = count_q - CNT_W'(1);
            if (cmd == CMD_POP_BACK) begin
              raddr  = tail_dec;
              tail_d = tail_dec;
            end else begin
              raddr  = head_q;
              head_d = head_inc;
            end
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  rbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (pop_ok_q) begin
      data_o = rdata;
    end else if (status_q == ST_EMPTY) begin
      data_o = '1;
    end else begin
      data_o = '0;
    end
  end

  assign status_o    = status_q;
  assign occupancy_o = OCC_W'(count_q);

endmodule
